### rtl/mesc_pkg.sv
// ----------------------------------------------------------------------------
// mesc_pkg
// Shared types and constants for the multi-turn encoder position scaler.
// ----------------------------------------------------------------------------
package mesc_pkg;

    localparam int POS_W       = 16;
    localparam int TOL_W       = 8;
    localparam int THR_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int DIV_CNT_W   = $clog2(POS_W);
    localparam int RES_BITS_DEF = 10;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(25);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(255);

    localparam logic [POS_W-1:0] MIN_UNSET  = 16'hFFFF;
    localparam logic [POS_W-1:0] MAX_UNSET  = 16'h0000;
    localparam logic [POS_W-1:0] FULL_OUT   = 16'hFFFF;
    localparam logic [POS_W-1:0] HELD_RESET = 16'h0001;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_TOL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_THR = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### rtl/multiturn_encoder_position_scaler.sv
// ----------------------------------------------------------------------------
// multiturn_encoder_position_scaler
// Multi-turn unwrap of an absolute encoder with two-button calibration and
// scaling of the calibrated position to 0..65535.
// ----------------------------------------------------------------------------
// Sequence: a request is captured, then unwrapped; until both limits are set
//   the result goes out directly; else it is clamped and then either saturated
//   for an empty span or scaled by the bit-serial divider. One request at a time;
//   the next is taken the cycle after the result enters the output register.
// Reset: async, active low; limits unset, offset 0, held position 1,
//   edge_tolerance 25, wrap_threshold 255. No clearing pass.
module multiturn_encoder_position_scaler #(
    parameter int RESOLUTION_BITS = mesc_pkg::RES_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input requests
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mesc_pkg::POS_W-1:0]     encoder_sample,
    input  logic                           min_button,
    input  logic                           max_button,
    // results
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mesc_pkg::POS_W-1:0]     wheel_position,
    output logic                           min_calibrated,
    output logic                           fully_calibrated,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mesc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mesc_pkg::THR_W-1:0]     cfg_data
);
    import mesc_pkg::*;

    localparam logic [POS_W-1:0] FULL_SCALE = POS_W'((32'd1 << RESOLUTION_BITS) - 32'd1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_PREP,
        S_DIV,
        S_OUT
    } state_t;

    state_t                     state_reg, state_next;
    logic [TOL_W-1:0]           tol_reg, tol_next;
    logic [THR_W-1:0]           thr_reg, thr_next;
    logic [RESOLUTION_BITS-1:0] prev_raw_reg, prev_raw_next;
    logic [RESOLUTION_BITS-1:0] raw_reg, raw_next;
    logic                       minb_reg, minb_next;
    logic                       maxb_reg, maxb_next;
    logic [POS_W-1:0]           offset_reg, offset_next;
    logic [POS_W-1:0]           lmin_reg, lmin_next;
    logic [POS_W-1:0]           lmax_reg, lmax_next;
    logic [POS_W-1:0]           held_reg, held_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic                       out_valid_reg, out_valid_next;
    logic [POS_W-1:0]           wheel_reg, wheel_next;
    logic                       minc_reg, minc_next;
    logic                       fullc_reg, fullc_next;

    logic [POS_W-1:0]  raw_ext, prev_ext, thr_ext, tol_ext;
    logic              overflow, underflow;
    logic [POS_W-1:0]  offset_wrap, pos_new;
    logic [POS_W-1:0]  span, rel;
    logic              lo_hit, hi_hit, inverted;
    logic              min_set;
    logic              div_start;
    logic [POS_W-1:0]  div_hi, div_lo, quotient;
    div_status_t       div_status;

    assign raw_ext  = POS_W'(raw_reg);
    assign prev_ext = POS_W'(prev_raw_reg);
    assign thr_ext  = POS_W'(thr_reg);
    assign tol_ext  = POS_W'(tol_reg);
    assign min_set  = lmin_reg != MIN_UNSET;

    // wrap detection; x > F - T is written as x + T > F to stay unsigned
    assign overflow  = (raw_ext <= thr_ext) && ((prev_ext + thr_ext) > FULL_SCALE);
    assign underflow = ((raw_ext + thr_ext) > FULL_SCALE) && (prev_ext < thr_ext);

    always_comb
    begin
        if (overflow)
            offset_wrap = offset_reg + FULL_SCALE;
        else if (underflow)
            offset_wrap = offset_reg - FULL_SCALE;
        else
            offset_wrap = offset_reg;
    end

    assign pos_new = raw_ext + offset_wrap;

    // clamp and dividend prep: rel * 65535 = {rel - 1, -rel} for rel > 0
    assign span     = lmax_reg - lmin_reg;
    assign lo_hit   = pos_reg <= lmin_reg;
    assign hi_hit   = pos_reg >= lmax_reg;
    assign inverted = lmax_reg <= lmin_reg;

    always_comb
    begin
        if (lo_hit)
            rel = '0;
        else if (hi_hit)
            rel = span;
        else
            rel = pos_reg - lmin_reg;
    end

    assign div_hi    = (rel == '0) ? '0 : rel - 1'b1;
    assign div_lo    = '0 - rel;
    assign div_start = (state_reg == S_PREP) && !inverted;

    mesc_divider u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend_hi (div_hi),
        .dividend_lo (div_lo),
        .divisor     (span),
        .quotient    (quotient),
        .status      (div_status)
    );

    always_comb
    begin
        state_next     = state_reg;
        tol_next       = tol_reg;
        thr_next       = thr_reg;
        prev_raw_next  = prev_raw_reg;
        raw_next       = raw_reg;
        minb_next      = minb_reg;
        maxb_next      = maxb_reg;
        offset_next    = offset_reg;
        lmin_next      = lmin_reg;
        lmax_next      = lmax_reg;
        held_next      = held_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        wheel_next     = wheel_reg;
        minc_next      = minc_reg;
        fullc_next     = fullc_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_EDGE_TOL: tol_next = cfg_data[TOL_W-1:0];
                REG_WRAP_THR: thr_next = cfg_data;
                default:      ;
            endcase
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    raw_next   = encoder_sample[RESOLUTION_BITS-1:0];
                    minb_next  = min_button;
                    maxb_next  = max_button;
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                prev_raw_next = raw_reg;
                if (!min_set)
                begin
                    if (minb_reg)
                    begin
                        lmin_next   = raw_ext + tol_ext;
                        offset_next = '0;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    offset_next = offset_wrap;
                    held_next   = pos_new;
                    pos_next    = pos_new;
                    if (lmax_reg == MAX_UNSET)
                    begin
                        if (maxb_reg)
                            lmax_next = pos_new - tol_ext;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (inverted)
                begin
                    held_next  = lo_hit ? '0 : FULL_OUT;
                    state_next = S_OUT;
                end
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    held_next  = quotient;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    wheel_next     = held_reg;
                    minc_next      = min_set;
                    fullc_next     = min_set && (lmax_reg != MAX_UNSET);
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tol_reg       <= TOL_RESET;
            thr_reg       <= THR_RESET;
            prev_raw_reg  <= '0;
            offset_reg    <= '0;
            lmin_reg      <= MIN_UNSET;
            lmax_reg      <= MAX_UNSET;
            held_reg      <= HELD_RESET;
            out_valid_reg <= 1'b0;
            wheel_reg     <= '0;
            minc_reg      <= 1'b0;
            fullc_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tol_reg       <= tol_next;
            thr_reg       <= thr_next;
            prev_raw_reg  <= prev_raw_next;
            offset_reg    <= offset_next;
            lmin_reg      <= lmin_next;
            lmax_reg      <= lmax_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            wheel_reg     <= wheel_next;
            minc_reg      <= minc_next;
            fullc_reg     <= fullc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg   <= raw_next;
        minb_reg  <= minb_next;
        maxb_reg  <= maxb_next;
        pos_reg   <= pos_next;
    end

    assign in_stall         = state_reg != S_IDLE;
    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign wheel_position   = wheel_reg;
    assign min_calibrated   = minc_reg;
    assign fully_calibrated = fullc_reg;

    // once captured, the minimum never goes back to unset
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(lmin_reg) != MIN_UNSET |-> lmin_reg != MIN_UNSET)
        else $error("minimum limit lost after capture");

    // divider only runs while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> state_reg == S_DIV)
        else $error("divider busy outside divide state");

    // an accepted request always starts the position step
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_POS)
        else $error("accepted request did not start");

    // a full calibration flag implies the minimum flag on every result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fully_calibrated |-> min_calibrated)
        else $error("fully calibrated without minimum");

endmodule

### rtl/mesc_divider.sv
// ----------------------------------------------------------------------------
// mesc_divider
// Bit-serial restoring divider: 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle. Caller guarantees the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module mesc_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mesc_pkg::POS_W-1:0] dividend_hi,
    input  logic [mesc_pkg::POS_W-1:0] dividend_lo,
    input  logic [mesc_pkg::POS_W-1:0] divisor,
    output logic [mesc_pkg::POS_W-1:0] quotient,
    output mesc_pkg::div_status_t      status
);
    import mesc_pkg::*;

    logic [POS_W-1:0]     rem_reg, rem_next;
    logic [POS_W-1:0]     quo_reg, quo_next;
    logic [POS_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [POS_W:0]       shifted;
    logic                 fits;

    // partial remainder stays below the divisor, so 17 bits cover the shift
    assign shifted = {rem_reg, quo_reg[POS_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend_hi;
            quo_next  = dividend_lo;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? POS_W'(shifted - {1'b0, dvs_reg}) : shifted[POS_W-1:0];
            quo_next = {quo_reg[POS_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(POS_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### tb/multiturn_encoder_position_scaler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiturn_encoder_position_scaler_test
// Checks the encoder unwrap, end-stop calibration and span scaling. Each
// accepted request goes through a local position tracker and the result
// stream is compared in order. A short table covers calibration and wrap
// corners, then random encoder motion runs under several register settings.
// ----------------------------------------------------------------------------
module multiturn_encoder_position_scaler_test;

    import mesc_pkg::*;

    localparam int FULL_SCALE  = (1 << RES_BITS_DEF) - 1;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 320;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [POS_W-1:0] wheel;
        logic             min_cal;
        logic             full_cal;
    } result_t;

    typedef struct {
        logic [POS_W-1:0] sample;
        logic             press_min;
        logic             press_max;
        bit               typed;
        result_t          want;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [POS_W-1:0]     encoder_sample = '0;
    logic                 min_button = 1'b0;
    logic                 max_button = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [POS_W-1:0]     wheel_position;
    logic                 min_calibrated;
    logic                 fully_calibrated;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [THR_W-1:0]     cfg_data = '0;

    // tracker state
    logic [TOL_W-1:0]     tol_reg  = TOL_RESET;
    logic [THR_W-1:0]     thr_reg  = THR_RESET;
    logic [13:0]          last_raw = '0;
    logic [POS_W-1:0]     turns    = '0;
    logic [POS_W-1:0]     cal_lo   = MIN_UNSET;
    logic [POS_W-1:0]     cal_hi   = MAX_UNSET;
    logic [POS_W-1:0]     hold_pos = HELD_RESET;

    result_t   pending_results[$];
    plan_row_t plan[$];
    int        errors = 0;
    bit        idle_on = 1'b1;
    int        hold_requests = 0;

    multiturn_encoder_position_scaler u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .encoder_sample  (encoder_sample),
        .min_button      (min_button),
        .max_button      (max_button),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .wheel_position  (wheel_position),
        .min_calibrated  (min_calibrated),
        .fully_calibrated(fully_calibrated),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [POS_W-1:0] scale_to_span(logic [POS_W-1:0] p);
        logic [31:0] span;
        logic [31:0] rel;
        // empty or inverted span collapses to the two ends
        if (cal_hi <= cal_lo)
            return (p <= cal_lo) ? '0 : FULL_OUT;
        span = 32'(cal_hi) - 32'(cal_lo);
        if (p <= cal_lo)
            rel = '0;
        else if (p >= cal_hi)
            rel = span;
        else
            rel = 32'(p) - 32'(cal_lo);
        return POS_W'((rel * 32'(FULL_OUT)) / span);
    endfunction

    function automatic result_t track_position(logic [POS_W-1:0] sample,
                                               logic press_min, logic press_max);
        int      now_raw;
        int      old_raw;
        int      lo_edge;
        int      hi_edge;
        result_t r;
        now_raw = int'(sample) & FULL_SCALE;
        old_raw = int'(last_raw);
        lo_edge = int'(thr_reg);
        hi_edge = FULL_SCALE - lo_edge;
        if (cal_lo == MIN_UNSET)
        begin
            if (press_min)
            begin
                cal_lo = POS_W'(now_raw + int'(tol_reg));
                turns  = '0;
            end
        end
        else
        begin
            if (now_raw <= lo_edge && old_raw > hi_edge)
                turns = turns + POS_W'(FULL_SCALE);
            else if (now_raw > hi_edge && old_raw < lo_edge)
                turns = turns - POS_W'(FULL_SCALE);
            hold_pos = POS_W'(now_raw) + turns;
            if (cal_hi == MAX_UNSET)
            begin
                if (press_max)
                    cal_hi = hold_pos - POS_W'(tol_reg);
            end
            else
                hold_pos = scale_to_span(hold_pos);
        end
        last_raw   = 14'(now_raw);
        r.wheel    = hold_pos;
        r.min_cal  = (cal_lo != MIN_UNSET);
        r.full_cal = (cal_lo != MIN_UNSET) && (cal_hi != MAX_UNSET);
        return r;
    endfunction

    function automatic void add_row(logic [POS_W-1:0] sample, logic press_min,
                                    logic press_max, bit typed = 1'b0,
                                    result_t want = '0);
        plan_row_t row;
        row.sample    = sample;
        row.press_min = press_min;
        row.press_max = press_max;
        row.typed     = typed;
        row.want      = want;
        plan.push_back(row);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_EDGE_TOL)
            tol_reg = data[TOL_W-1:0];
        else if (idx == REG_WRAP_THR)
            thr_reg = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_request(logic [POS_W-1:0] sample, logic press_min,
                                logic press_max, bit typed, result_t want);
        int      gap;
        result_t r;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        encoder_sample <= sample;
        min_button     <= press_min;
        max_button     <= press_max;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = track_position(sample, press_min, press_max);
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result side: per-result stall draw, plus long hold-offs on request
    initial
    begin
        result_t want;
        int      stall_left;
        int      hold_left;
        int      hold_seen;
        stall_left = 0;
        hold_left  = 0;
        hold_seen  = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: wheel_position %0d", wheel_position);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (wheel_position !== want.wheel)
                    begin
                        $error("wheel_position: expected %0d, got %0d",
                               want.wheel, wheel_position);
                        errors++;
                    end
                    if (min_calibrated !== want.min_cal)
                    begin
                        $error("min_calibrated: expected %0d, got %0d",
                               want.min_cal, min_calibrated);
                        errors++;
                    end
                    if (fully_calibrated !== want.full_cal)
                    begin
                        $error("fully_calibrated: expected %0d, got %0d",
                               want.full_cal, fully_calibrated);
                        errors++;
                    end
                end
                stall_left = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog: cycles with no handshake on any channel
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        result_t     idle_res;
        result_t     cal_res;
        plan_row_t   row;
        bit          inverted_run;
        int          walk;
        int          delta;
        int          pick;
        logic [POS_W-1:0] s;
        logic [TOL_W-1:0] tol_pick;
        logic [THR_W-1:0] thr_pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pick = $urandom_range(0, 2);
        tol_pick = (pick == 0) ? '0 : (pick == 1) ? '1 : TOL_W'($urandom_range(0, 255));
        // top data bit is outside the tolerance field and must be dropped
        write_reg(REG_EDGE_TOL, {1'($urandom), tol_pick});
        // occasionally capture a max at or below the min to hit the flat span
        inverted_run = ($urandom_range(0, 3) == 0);

        idle_res = '{wheel: HELD_RESET, min_cal: 1'b0, full_cal: 1'b0};
        cal_res  = '{wheel: HELD_RESET, min_cal: 1'b1, full_cal: 1'b0};
        add_row(16'h0000, 1'b0, 1'b0, 1'b1, idle_res);
        add_row(16'hFFFF, 1'b0, 1'b1, 1'b1, idle_res);   // max ignored before min
        add_row(16'hFC00, 1'b0, 1'b0, 1'b1, idle_res);   // no unwrap while uncalibrated
        add_row(16'h03FF, 1'b0, 1'b0, 1'b1, idle_res);
        add_row(16'hA464, 1'b1, 1'b1, 1'b1, cal_res);    // min capture at raw 100
        add_row(16'h0064, 1'b1, 1'b0);                   // second min press ignored
        add_row(16'd900,  1'b0, 1'b0);                   // underflow, offset goes negative
        add_row(16'd50,   1'b0, 1'b0);                   // overflow back
        add_row(16'd1023, 1'b0, 1'b0);
        add_row(16'd0,    1'b0, 1'b0);
        add_row(16'd255,  1'b0, 1'b0);                   // threshold boundaries
        add_row(16'd769,  1'b0, 1'b0);
        add_row(16'd768,  1'b0, 1'b0);
        add_row(16'd255,  1'b0, 1'b0);
        add_row(16'd500,  1'b0, 1'b0);
        add_row(POS_W'(tol_pick), 1'b0, 1'b1);           // max would be 0: stays unset
        add_row(16'd500,  1'b0, 1'b0);
        add_row(inverted_run ? POS_W'(tol_pick) + 16'd1 : 16'd1000, 1'b0, 1'b1);
        add_row(16'h0000, 1'b1, 1'b1);                   // both buttons now ignored
        add_row(16'hFFFF, 1'b0, 1'b0);
        add_row(16'd500,  1'b0, 1'b0);
        add_row(16'd10,   1'b0, 1'b0);                   // below min clamps to 0
        add_row(16'h5414, 1'b0, 1'b0);
        add_row(16'd800,  1'b0, 1'b0);

        foreach (plan[i])
        begin
            row = plan[i];
            send_request(row.sample, row.press_min, row.press_max, row.typed, row.want);
        end
        walk = 800;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            in_valid <= 1'b0;
            wait_drained();
            tol_pick = (ph == 0) ? '0 : (ph == 1) ? '1 : TOL_W'($urandom_range(0, 255));
            thr_pick = (ph == 0) ? '0 : (ph == 1) ? '1 :
                       (ph == 3) ? THR_RESET : THR_W'($urandom_range(0, 511));
            write_reg(REG_EDGE_TOL, {1'($urandom), tol_pick});
            write_reg(REG_WRAP_THR, thr_pick);
            idle_on = !(ph == 1 || ph == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == 100 && (ph == 2 || ph == 5))
                    hold_requests++;
                if (n == 160 && ph == 3)
                begin
                    in_valid <= 1'b0;
                    wait_drained();
                end
                if ($urandom_range(0, 9) == 0)
                    s = POS_W'($urandom);
                else
                begin
                    // encoder motion; large steps cross the wrap window
                    delta = int'($urandom_range(0, 800)) - 400;
                    walk  = (walk + delta) & FULL_SCALE;
                    s = (POS_W'($urandom) & ~POS_W'(FULL_SCALE)) | POS_W'(walk);
                end
                walk = int'(s) & FULL_SCALE;
                send_request(s, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                             1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
